[rtl/core/snhs_pkg.sv]
// Shared types and constants for the seeded name hash block.
// Used by snhs_front, snhs_queue, snhs_back and seeded_name_hash_to_seed.
// No dependencies.
package snhs_pkg;

  // FNV-1a 64-bit constants. The prime is 2^40 + 0x1b3.
  localparam logic [63:0] FNV_BASIS       = 64'hcbf29ce484222325;
  localparam logic [8:0]  FNV_PRIME_LO    = 9'h1b3;
  localparam int          FNV_PRIME_SHIFT = 40;

  // Splitmix64 finalizer constants.
  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Configuration port.
  localparam int              CFG_ADDR_W       = 1;
  localparam int              CFG_DATA_W       = 64;
  localparam logic [CFG_ADDR_W-1:0] ADDR_BASE_SEED = 1'b0;

  // One classified byte as it travels from front to back.
  typedef struct packed {
    logic [7:0] name_byte;
    logic       fold;    // byte is nonzero and goes into the hash
    logic       ends;    // byte closes the name and triggers a result
    logic       starts;  // byte opens a new name
  } snhs_entry_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic empty;
    logic full;
  } snhs_qstat_t;

  // Back part status.
  typedef struct packed {
    logic busy;    // working on a name end
    logic finish;  // result is written to the output register this cycle
  } snhs_bstat_t;

endpackage

[rtl/core/snhs_front.sv]
// Front part of the seeded name hash block: accepts input beats and classifies them.
// Depends on snhs_pkg; feeds snhs_queue.
module snhs_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           name_byte,
  input  logic                 last,
  input  snhs_pkg::snhs_qstat_t qstat,
  output logic                 push,
  output snhs_pkg::snhs_entry_t push_entry
);

  // Set when the next accepted beat opens a new name.
  logic start_pending;

  assign in_stall = qstat.full;
  assign push     = in_valid && !qstat.full;

  // Classify the beat.
  always_comb begin
    push_entry.name_byte = name_byte;
    push_entry.fold      = (name_byte != 8'd0);
    push_entry.ends      = (name_byte == 8'd0) || last;
    push_entry.starts    = start_pending;
  end

  // Track name boundaries.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pending <= 1'b1;
    end else if (push) begin
      start_pending <= push_entry.ends;
    end
  end

endmodule

[rtl/core/snhs_queue.sv]
// Short queue of classified beats between the front and back parts.
// Depends on snhs_pkg for the entry and status types.
module snhs_queue #(
  parameter int DEPTH = snhs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  snhs_pkg::snhs_entry_t push_entry,
  input  logic                  pop,
  output snhs_pkg::snhs_entry_t head,
  output snhs_pkg::snhs_qstat_t qstat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  snhs_pkg::snhs_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign qstat.empty = (count == CNT_W'(0));
  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = slots[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/core/snhs_back.sv]
// Back part of the seeded name hash block: FNV-1a folding, splitmix64 finalizer
// on a shared 32x32 multiplier, and the output register. Depends on snhs_pkg.
module snhs_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [63:0]           base_seed,
  input  snhs_pkg::snhs_entry_t head,
  input  snhs_pkg::snhs_qstat_t qstat,
  output logic                  pop,
  output snhs_pkg::snhs_bstat_t bstat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [63:0]           derived_seed
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_GOLD = 7'b0000010,
    ST_MUL0 = 7'b0000100,
    ST_MUL1 = 7'b0001000,
    ST_MUL2 = 7'b0010000,
    ST_XS   = 7'b0100000,
    ST_FIN  = 7'b1000000
  } back_state_t;

  back_state_t state;
  logic [63:0] hash;
  logic [63:0] opnd;
  logic [63:0] acc;
  logic        pass_b;

  logic [63:0] h_base;
  logic [63:0] h_x;
  logic [63:0] h_fold;
  logic [63:0] mix_k;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] z_gold;
  logic        out_free;

  assign pop      = (state == ST_IDLE) && !qstat.empty;
  assign out_free = !out_valid || !out_stall;

  assign bstat.busy   = (state != ST_IDLE);
  assign bstat.finish = (state == ST_FIN) && out_free;

  // One FNV-1a step; the prime is split into a small multiply and a shift.
  always_comb begin
    h_base = head.starts ? (base_seed ^ snhs_pkg::FNV_BASIS) : hash;
    h_x    = h_base ^ {56'd0, head.name_byte};
    h_fold = head.fold ?
             ((h_x * 64'(snhs_pkg::FNV_PRIME_LO)) + (h_x << snhs_pkg::FNV_PRIME_SHIFT)) :
             h_base;
  end

  // Partial product selection for the 64-bit modular multiply.
  always_comb begin
    mix_k = pass_b ? snhs_pkg::MIX_MUL_B : snhs_pkg::MIX_MUL_A;
    case (state)
      ST_MUL1: begin
        mul_a = opnd[31:0];
        mul_b = mix_k[63:32];
      end
      ST_MUL2: begin
        mul_a = opnd[63:32];
        mul_b = mix_k[31:0];
      end
      default: begin
        mul_a = opnd[31:0];
        mul_b = mix_k[31:0];
      end
    endcase
    prod   = 64'(mul_a) * 64'(mul_b);
    z_gold = hash + snhs_pkg::GOLDEN_STEP;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pass_b    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The output beat leaves unless a new result replaces it this cycle.
      if (out_valid && !out_stall && !bstat.finish) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            hash <= h_fold;
            if (head.ends) begin
              state <= ST_GOLD;
            end
          end
        end
        ST_GOLD: begin
          opnd   <= z_gold ^ (z_gold >> 30);
          pass_b <= 1'b0;
          state  <= ST_MUL0;
        end
        ST_MUL0: begin
          acc   <= prod;
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          acc   <= acc + {prod[31:0], 32'd0};
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          acc   <= acc + {prod[31:0], 32'd0};
          state <= pass_b ? ST_FIN : ST_XS;
        end
        ST_XS: begin
          opnd   <= acc ^ (acc >> 27);
          pass_b <= 1'b1;
          state  <= ST_MUL0;
        end
        ST_FIN: begin
          if (out_free) begin
            derived_seed <= acc ^ (acc >> 31);
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/seeded_name_hash_to_seed.sv]
// Top level of the seeded name hash block: configuration port and the
// front, queue and back parts. Depends on snhs_pkg, snhs_front, snhs_queue, snhs_back.

// Derives a 64-bit seed from a name delivered one byte per beat. The first byte of a
// name loads the hash with base_seed XOR the FNV-1a offset basis; each nonzero byte
// is folded in FNV-1a style; a zero byte or a beat with last set ends the name, and
// the splitmix64-finalized hash appears as one result beat on derived_seed. The front
// part takes one input beat per cycle while the queue (QUEUE_DEPTH entries) has room.
// The back part folds a byte that does not end a name straight from ST_IDLE; a byte that
// ends a name runs ST_GOLD, ST_MUL0, ST_MUL1, ST_MUL2, ST_XS, the multiply states again
// and ST_FIN before the next pop: two 64x64 finalizer multiplies, each done as three
// partial products on one shared 32x32 multiplier, and ST_FIN waits while out_stall holds
// the output register. base_seed sits at address 0 and is sampled when a name begins.
module seeded_name_hash_to_seed #(
  parameter int QUEUE_DEPTH = snhs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [snhs_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [snhs_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [snhs_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      name_byte,
  input  logic                            last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [63:0]                     derived_seed
);

  logic [63:0]           base_seed;
  logic                  push;
  logic                  pop;
  snhs_pkg::snhs_entry_t push_entry;
  snhs_pkg::snhs_entry_t head;
  snhs_pkg::snhs_qstat_t qstat;
  snhs_pkg::snhs_bstat_t bstat;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr == snhs_pkg::ADDR_BASE_SEED) ? base_seed : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_seed <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == snhs_pkg::ADDR_BASE_SEED)) begin
      base_seed <= pwdata;
    end
  end

  // Front: accept and classify beats.
  snhs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .name_byte  (name_byte),
    .last       (last),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Queue between front and back.
  snhs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  // Back: hashing, finalizer and output register.
  snhs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .base_seed    (base_seed),
    .head         (head),
    .qstat        (qstat),
    .pop          (pop),
    .bstat        (bstat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .derived_seed (derived_seed)
  );

  // An accepted beat is held in the queue on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !qstat.empty)
    else $error("accepted beat did not reach the queue");

  // A new result only appears when the finalizer completes.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(bstat.finish))
    else $error("result raised without a finished finalizer");

  // The back part never pulls from the queue while finalizing.
  assert property (@(posedge clk) disable iff (rst)
    bstat.busy |-> !pop)
    else $error("queue popped while the finalizer is busy");

endmodule

[sim/tb.sv]
// Self-checking bench for seeded_name_hash_to_seed. It streams name bytes, predicts each
// derived seed with a local FNV-1a and splitmix64 model, and checks every result beat.
// Depends on snhs_pkg and the seeded_name_hash_to_seed RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] OFFSET_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] NAME_PRIME   = 64'h00000100000001b3;
  localparam logic [63:0] GOLDEN_INC   = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_A        = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_B        = 64'h94d049bb133111eb;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_BEATS = 1900;
  localparam int PHASES       = 6;
  localparam int MAX_REPORTS  = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [snhs_pkg::CFG_ADDR_W-1:0] paddr = snhs_pkg::ADDR_BASE_SEED;
  logic [snhs_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [snhs_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] name_byte = 8'd0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] derived_seed;

  // When set, neither side idles or stalls at random.
  bit calm = 1'b0;

  // Local copy of the block's state and configuration.
  logic [63:0] seed_cfg = '0;
  logic [63:0] name_hash = '0;
  bit name_open = 1'b0;
  logic [63:0] expected_seeds[$];

  int mismatches = 0;
  int beats_sent = 0;
  int names_closed = 0;
  int seeds_checked = 0;
  int seed_writes = 0;

  seeded_name_hash_to_seed u_top (.*);

  always #6 clk = ~clk;

  // The result side stalls at random outside calm stretches.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 12);
  end

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected %016h, got %016h", $time, what, want, got);
  endtask

  function automatic logic [63:0] splitmix_finish(input logic [63:0] h);
    logic [63:0] z;
    z = h + GOLDEN_INC;
    z = (z ^ (z >> 30)) * MIX_A;
    z = (z ^ (z >> 27)) * MIX_B;
    return z ^ (z >> 31);
  endfunction

  // Fold one accepted beat into the running hash; a name end queues a seed.
  task automatic fold_name_beat(input logic [7:0] b, input logic l);
    if (!name_open) begin
      name_hash = seed_cfg ^ OFFSET_BASIS;
      name_open = 1'b1;
    end
    if (b != 8'd0) name_hash = (name_hash ^ {56'd0, b}) * NAME_PRIME;
    if (b == 8'd0 || l) begin
      expected_seeds.push_back(splitmix_finish(name_hash));
      name_open = 1'b0;
      names_closed++;
    end
  endtask

  // Each accepted result beat is checked against the oldest predicted seed.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_seeds.size() == 0) begin
        note_mismatch("result beat with nothing expected", '0, derived_seed);
      end else begin
        if (derived_seed !== expected_seeds[0])
          note_mismatch("derived_seed", expected_seeds[0], derived_seed);
        void'(expected_seeds.pop_front());
        seeds_checked++;
      end
    end
  end

  // Offer one beat, with random idle cycles ahead of it, and hold it until taken.
  task automatic send_beat(input logic [7:0] b, input logic l);
    while (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    name_byte <= b;
    last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_name_beat(b, l);
    beats_sent++;
  endtask

  // Stop offering beats, wait for every predicted seed, then let a partial name settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_seeds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the base seed through the register port, then read it back.
  task automatic write_base_seed(input logic [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= snhs_pkg::ADDR_BASE_SEED;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    seed_cfg = v;
    seed_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== v) note_mismatch("base_seed readback", v, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Empty names: a lone zero byte, with and without last.
  task automatic test_empty_names();
    send_beat(8'h00, 1'b0);
    send_beat(8'h00, 1'b1);
    wait_drained();
  endtask

  // Byte extremes; one name ends on last with a nonzero byte, one on a zero byte.
  task automatic test_byte_extremes();
    send_beat(8'h01, 1'b0);
    send_beat(8'hff, 1'b0);
    send_beat(8'h80, 1'b1);
    send_beat(8'h7f, 1'b0);
    send_beat(8'h00, 1'b0);
    wait_drained();
  endtask

  // Base seed at all ones and with only its end bits set.
  task automatic test_seed_extremes();
    write_base_seed('1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hff, 1'b1);
    wait_drained();
    write_base_seed(64'h8000000000000001);
    send_beat(8'h55, 1'b0);
    send_beat(8'haa, 1'b0);
    send_beat(8'h00, 1'b1);
    wait_drained();
  endtask

  // A seed written in the middle of a name only applies from the next name on.
  task automatic test_mid_name_seed_write();
    write_base_seed({$urandom, $urandom});
    send_beat(8'h6e, 1'b0);
    send_beat(8'h61, 1'b0);
    wait_drained();
    write_base_seed({$urandom, $urandom});
    send_beat(8'h6d, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h78, 1'b1);
    wait_drained();
  endtask

  // Random names under several seeds; mostly well-formed names, some loose bytes.
  task automatic test_random_names();
    int len;
    int ending;
    int phase_start;
    logic [63:0] seed;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1: seed = '1;
        2: seed = '0;
        4: seed = {1'b1, 31'($urandom), $urandom};
        default: seed = {$urandom, $urandom};
      endcase
      write_base_seed(seed);
      calm = (phase == 3);
      phase_start = beats_sent;
      while (beats_sent - phase_start < RANDOM_BEATS / PHASES) begin
        if ($urandom_range(99) < 85) begin
          // Ending: 0 zero byte, 1 zero byte with last, 2 last on the final byte.
          len = $urandom_range(10);
          ending = $urandom_range(2);
          for (int i = 0; i < len; i++)
            send_beat(8'($urandom_range(255, 1)), (i == len - 1) && (ending == 2));
          if (len == 0 || ending != 2)
            send_beat(8'h00, ending == 1);
        end else begin
          send_beat(8'($urandom_range(255)), $urandom_range(3) == 0);
        end
      end
      wait_drained();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_names();
    test_byte_extremes();
    test_seed_extremes();
    test_mid_name_seed_write();
    test_random_names();
    $display("Sent %0d name beats, closed %0d names, checked %0d derived seeds.",
             beats_sent, names_closed, seeds_checked);
    $display("Used %0d base seed settings; %0d mismatching checks.",
             seed_writes, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  initial begin
    #10_000_000;
    $display("Timeout with %0d seeds still expected.", expected_seeds.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[seeded_name_hash_to_seed.f]
rtl/core/snhs_pkg.sv
rtl/core/snhs_front.sv
rtl/core/snhs_queue.sv
rtl/core/snhs_back.sv
rtl/core/seeded_name_hash_to_seed.sv
sim/tb.sv
